@@ design/cpsv_pkg.sv @@
// ----------------------------------------------------------------------------
// cpsv_pkg
// Shared types and constants for the position/velocity state vector unit.
// ----------------------------------------------------------------------------
package cpsv_pkg;

   // number of CORDIC rotation cells (12 to 32)
   localparam int CORDIC_STAGES = 24;

   // one full turn in Q10.22 degrees
   localparam logic signed [33:0] DEG_TURN = 34'sd1509949440;

   // reciprocal of 45 for 31-bit dividends: ceil(2^37 / 45)
   localparam logic [31:0] RECIP45_WIDE  = 32'd3054198967;
   localparam int          RECIP45_SHIFT = 37;
   // reciprocal of 45 for 13-bit dividends: ceil(2^19 / 45)
   localparam logic [13:0] RECIP45_NARROW = 14'd11651;
   localparam int          RECIP45_NSHIFT = 19;

   // CORDIC start value: gain compensation 0.60725 in Q2.30
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   // configuration register indexes
   localparam logic [1:0] CSR_VELOCITY_SCALE = 2'd0;
   localparam logic [1:0] CSR_CENTURY_FACTOR = 2'd1;

   // reset values of the configuration registers
   localparam logic [31:0] VELOCITY_SCALE_RESET = 32'd3539071;
   localparam logic [9:0]  CENTURY_FACTOR_RESET = 10'd100;

   // one CORDIC rotator: cosine, sine and residual angle
   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
   } rot_type;

   // everything one star carries through the rotation chain
   typedef struct packed {
      logic               valid;
      rot_type            lon;
      rot_type            lat;
      logic               flip_lon;
      logic               flip_lat;
      logic signed [48:0] rdot;
      logic signed [41:0] adot;
      logic signed [41:0] ddot;
   } cell_type;

endpackage

@@ design/cpsv_prep.sv @@
// ----------------------------------------------------------------------------
// cpsv_prep
// Front end: reduces both angles to binary angles, folds them into the
// right half plane and computes the radial and proper-motion rates.
// ----------------------------------------------------------------------------
module cpsv_prep import cpsv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [31:0] longitude_deg,
   input  logic signed [29:0] latitude_deg,
   input  logic signed [31:0] pm_longitude,
   input  logic signed [31:0] pm_latitude,
   input  logic signed [31:0] radial_velocity,
   input  logic [31:0]        parallax_arcsec,
   input  logic [31:0]        velocity_scale,
   input  logic [9:0]         century_factor,
   output cell_type           cell_out
);

   // reduce degrees modulo one turn into [0, turn)
   function automatic logic [30:0] reduce_deg(input logic signed [31:0] v);
      logic signed [33:0] e;
      logic signed [33:0] r;
      e = 34'(v);
      if (e >= DEG_TURN) begin
         r = e - DEG_TURN;
      end else if (e < 0) begin
         r = e + DEG_TURN;
         if (r < 0) begin
            r = r + DEG_TURN;
         end
      end else begin
         r = e;
      end
      return r[30:0];
   endfunction

   // round(m * 2^32 / turn) = floor((128 m + 22) / 45), split on m / 45
   function automatic logic [31:0] bin_angle(input logic [62:0] p, input logic [30:0] m);
      logic [25:0] q;
      logic [30:0] rem;
      logic [12:0] t;
      logic [26:0] tp;
      logic [7:0]  q2;
      q   = p[62:RECIP45_SHIFT];
      rem = m - 31'(q) * 31'd45;
      t   = {rem[5:0], 7'b0} + 13'd22;
      tp  = 27'(t) * 27'(RECIP45_NARROW);
      q2  = tp[26:RECIP45_NSHIFT];
      return 32'({q, 7'b0}) + 32'(q2);
   endfunction

   // stage 0: reduced angles, scale product, proper-motion rates
   logic               s0_valid_ff;
   logic [30:0]        s0_mlon_ff, s0_mlat_ff;
   logic [63:0]        s0_vprod_ff;
   logic signed [41:0] s0_adot_ff, s0_ddot_ff;
   logic               s0_rvneg_ff;
   logic [31:0]        s0_rvmag_ff;

   logic signed [42:0] adot_in, ddot_in;

   assign adot_in = pm_longitude * $signed({1'b0, century_factor});
   assign ddot_in = pm_latitude * $signed({1'b0, century_factor});

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_mlon_ff  <= reduce_deg(longitude_deg);
         s0_mlat_ff  <= reduce_deg(32'(latitude_deg));
         s0_vprod_ff <= 64'(velocity_scale) * 64'(parallax_arcsec);
         s0_adot_ff  <= $signed(adot_in[41:0]);
         s0_ddot_ff  <= $signed(ddot_in[41:0]);
         s0_rvneg_ff <= radial_velocity[31];
         s0_rvmag_ff <= radial_velocity[31] ? (~radial_velocity + 32'd1) : radial_velocity;
      end
   end

   // stage 1: reciprocal products, rounded scale times parallax
   logic               s1_valid_ff;
   logic [62:0]        s1_plon_ff, s1_plat_ff;
   logic [30:0]        s1_mlon_ff, s1_mlat_ff;
   logic [39:0]        s1_vp_ff;
   logic signed [41:0] s1_adot_ff, s1_ddot_ff;
   logic               s1_rvneg_ff;
   logic [31:0]        s1_rvmag_ff;

   logic [63:0] vp_sum_in;

   assign vp_sum_in = s0_vprod_ff + 64'd8388608;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_plon_ff  <= 63'(s0_mlon_ff) * 63'(RECIP45_WIDE);
         s1_plat_ff  <= 63'(s0_mlat_ff) * 63'(RECIP45_WIDE);
         s1_mlon_ff  <= s0_mlon_ff;
         s1_mlat_ff  <= s0_mlat_ff;
         s1_vp_ff    <= vp_sum_in[63:24];
         s1_adot_ff  <= s0_adot_ff;
         s1_ddot_ff  <= s0_ddot_ff;
         s1_rvneg_ff <= s0_rvneg_ff;
         s1_rvmag_ff <= s0_rvmag_ff;
      end
   end

   // stage 2: binary angles, partial products of the radial rate
   logic               s2_valid_ff;
   logic [31:0]        s2_alon_ff, s2_alat_ff;
   logic [51:0]        s2_pph_ff, s2_ppl_ff;
   logic signed [41:0] s2_adot_ff, s2_ddot_ff;
   logic               s2_rvneg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_alon_ff  <= bin_angle(s1_plon_ff, s1_mlon_ff);
         s2_alat_ff  <= bin_angle(s1_plat_ff, s1_mlat_ff);
         s2_pph_ff   <= 52'(s1_vp_ff[39:20]) * 52'(s1_rvmag_ff);
         s2_ppl_ff   <= 52'(s1_vp_ff[19:0]) * 52'(s1_rvmag_ff);
         s2_adot_ff  <= s1_adot_ff;
         s2_ddot_ff  <= s1_ddot_ff;
         s2_rvneg_ff <= s1_rvneg_ff;
      end
   end

   // stage 3: fold into [-90, 90) degrees, seed the rotators, finish rdot
   cell_type    cell_ff, cell_in;
   logic [72:0] rsum;
   logic        flip_lon, flip_lat;

   always_comb begin
      rsum     = 73'({s2_pph_ff, 20'b0}) + 73'(s2_ppl_ff) + 73'd8388608;
      flip_lon = s2_alon_ff[31] ^ s2_alon_ff[30];
      flip_lat = s2_alat_ff[31] ^ s2_alat_ff[30];
      cell_in.valid    = s2_valid_ff;
      cell_in.flip_lon = flip_lon;
      cell_in.flip_lat = flip_lat;
      cell_in.lon.x    = CORDIC_GAIN;
      cell_in.lon.y    = '0;
      cell_in.lon.z    = 34'($signed({s2_alon_ff[31] ^ flip_lon, s2_alon_ff[30:0]}));
      cell_in.lat.x    = CORDIC_GAIN;
      cell_in.lat.y    = '0;
      cell_in.lat.z    = 34'($signed({s2_alat_ff[31] ^ flip_lat, s2_alat_ff[30:0]}));
      cell_in.rdot     = s2_rvneg_ff ? -$signed(rsum[72:24]) : $signed(rsum[72:24]);
      cell_in.adot     = s2_adot_ff;
      cell_in.ddot     = s2_ddot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

@@ design/cpsv_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// cpsv_cordic_cell
// One CORDIC rotation step for both angles; hands the star to the next cell.
// ----------------------------------------------------------------------------
module cpsv_cordic_cell import cpsv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic [4:0] stage_idx,
   input  cell_type   cell_in,
   output cell_type   cell_out
);

   // arctangent of 2^-i in binary angle units
   function automatic logic [29:0] atan_value(input logic [4:0] i);
      logic [29:0] a;
      unique case (i)
         5'd0:  a = 30'd536870912;
         5'd1:  a = 30'd316933406;
         5'd2:  a = 30'd167458907;
         5'd3:  a = 30'd85004756;
         5'd4:  a = 30'd42667331;
         5'd5:  a = 30'd21354465;
         5'd6:  a = 30'd10679838;
         5'd7:  a = 30'd5340245;
         5'd8:  a = 30'd2670163;
         5'd9:  a = 30'd1335087;
         5'd10: a = 30'd667544;
         5'd11: a = 30'd333772;
         5'd12: a = 30'd166886;
         5'd13: a = 30'd83443;
         5'd14: a = 30'd41722;
         5'd15: a = 30'd20861;
         5'd16: a = 30'd10430;
         5'd17: a = 30'd5215;
         5'd18: a = 30'd2608;
         5'd19: a = 30'd1304;
         5'd20: a = 30'd652;
         5'd21: a = 30'd326;
         5'd22: a = 30'd163;
         5'd23: a = 30'd81;
         5'd24: a = 30'd41;
         5'd25: a = 30'd20;
         5'd26: a = 30'd10;
         5'd27: a = 30'd5;
         5'd28: a = 30'd3;
         5'd29: a = 30'd1;
         5'd30: a = 30'd1;
         default: a = 30'd0;
      endcase
      return a;
   endfunction

   function automatic rot_type rotate(input rot_type r, input logic [4:0] i);
      rot_type            o;
      logic signed [33:0] xs;
      logic signed [33:0] ys;
      logic signed [33:0] at;
      xs = r.x >>> i;
      ys = r.y >>> i;
      at = $signed(34'(atan_value(i)));
      if (!r.z[33]) begin
         o.x = r.x - ys;
         o.y = r.y + xs;
         o.z = r.z - at;
      end else begin
         o.x = r.x + ys;
         o.y = r.y - xs;
         o.z = r.z + at;
      end
      return o;
   endfunction

   cell_type stage_ff, stage_in;

   always_comb begin
      stage_in     = cell_in;
      stage_in.lon = rotate(cell_in.lon, stage_idx);
      stage_in.lat = rotate(cell_in.lat, stage_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign cell_out = stage_ff;

endmodule

@@ design/cpsv_combine.sv @@
// ----------------------------------------------------------------------------
// cpsv_combine
// Back end: builds the axis triad, scales it by the three rates, sums and
// saturates into the result register.
// ----------------------------------------------------------------------------
module cpsv_combine import cpsv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  cell_type           cell_in,
   output logic               out_valid,
   output logic signed [31:0] pos_x,
   output logic signed [31:0] pos_y,
   output logic signed [31:0] pos_z,
   output logic signed [47:0] vel_x,
   output logic signed [47:0] vel_y,
   output logic signed [47:0] vel_z
);

   typedef struct packed {
      logic        neg;
      logic [56:0] ph;
      logic [55:0] pl;
   } term_type;

   localparam logic signed [31:0] POS_MAX = 32'sd1073741824;
   localparam logic signed [31:0] POS_MIN = -32'sd1073741824;
   localparam logic signed [53:0] VEL_MAX = 54'sd140737488355327;
   localparam logic signed [53:0] VEL_MIN = -54'sd140737488355328;

   // Q2.30 product rounded back to Q2.30
   function automatic logic signed [31:0] rnd_q30(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p + 64'sd536870912;
      return $signed(s[61:30]);
   endfunction

   function automatic logic signed [31:0] sat_pos(input logic signed [31:0] e);
      logic signed [31:0] r;
      if (e > POS_MAX) begin
         r = POS_MAX;
      end else if (e < POS_MIN) begin
         r = POS_MIN;
      end else begin
         r = e;
      end
      return r;
   endfunction

   // split magnitude product of rate and axis component
   function automatic term_type make_term(input logic signed [48:0] r,
                                          input logic signed [31:0] e);
      term_type   t;
      logic [48:0] ar;
      logic [31:0] ae;
      ar    = r[48] ? (~r + 49'd1) : r;
      ae    = e[31] ? (~e + 32'd1) : e;
      t.neg = r[48] ^ e[31];
      t.ph  = 57'(ar[48:24]) * 57'(ae);
      t.pl  = 56'(ar[23:0]) * 56'(ae);
      return t;
   endfunction

   // round half away from zero to Q.16 and restore the sign
   function automatic logic signed [51:0] finish_term(input term_type t);
      logic [81:0] s;
      logic [51:0] m;
      s = 82'({t.ph, 24'b0}) + 82'(t.pl) + 82'd536870912;
      m = s[81:30];
      return t.neg ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [47:0] sat_vel(input logic signed [53:0] v);
      logic signed [53:0] r;
      if (v > VEL_MAX) begin
         r = VEL_MAX;
      end else if (v < VEL_MIN) begin
         r = VEL_MIN;
      end else begin
         r = v;
      end
      return $signed(r[47:0]);
   endfunction

   // stage 1: sine/cosine with fold undone, four axis products
   logic signed [31:0] cl, sl, cb, sb;
   logic signed [33:0] ncl, nsl, ncb, nsb;

   always_comb begin
      ncl = cell_in.flip_lon ? -cell_in.lon.x : cell_in.lon.x;
      nsl = cell_in.flip_lon ? -cell_in.lon.y : cell_in.lon.y;
      ncb = cell_in.flip_lat ? -cell_in.lat.x : cell_in.lat.x;
      nsb = cell_in.flip_lat ? -cell_in.lat.y : cell_in.lat.y;
      cl  = $signed(ncl[31:0]);
      sl  = $signed(nsl[31:0]);
      cb  = $signed(ncb[31:0]);
      sb  = $signed(nsb[31:0]);
   end

   logic               q1_valid_ff;
   logic signed [31:0] q1_clcb_ff, q1_slcb_ff, q1_clsb_ff, q1_slsb_ff;
   logic signed [31:0] q1_cb_ff, q1_sb_ff;
   logic signed [48:0] q1_rdot_ff;
   logic signed [41:0] q1_adot_ff, q1_ddot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_valid_ff <= 1'b0;
      end else if (en) begin
         q1_valid_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q1_clcb_ff <= rnd_q30(64'(cl) * 64'(cb));
         q1_slcb_ff <= rnd_q30(64'(sl) * 64'(cb));
         q1_clsb_ff <= rnd_q30(64'(cl) * 64'(sb));
         q1_slsb_ff <= rnd_q30(64'(sl) * 64'(sb));
         q1_cb_ff   <= cb;
         q1_sb_ff   <= sb;
         q1_rdot_ff <= cell_in.rdot;
         q1_adot_ff <= cell_in.adot;
         q1_ddot_ff <= cell_in.ddot;
      end
   end

   // stage 2: rate times axis partial products, saturated position
   logic               q2_valid_ff;
   term_type           q2_term_ff [8];
   logic signed [31:0] q2_pos_ff [3];
   logic signed [48:0] adot_w, ddot_w;

   assign adot_w = 49'(q1_adot_ff);
   assign ddot_w = 49'(q1_ddot_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         q2_valid_ff <= 1'b0;
      end else if (en) begin
         q2_valid_ff <= q1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // x: radial, longitude, latitude terms
         q2_term_ff[0] <= make_term(q1_rdot_ff, q1_clcb_ff);
         q2_term_ff[1] <= make_term(adot_w, -q1_slcb_ff);
         q2_term_ff[2] <= make_term(ddot_w, -q1_clsb_ff);
         // y
         q2_term_ff[3] <= make_term(q1_rdot_ff, q1_slcb_ff);
         q2_term_ff[4] <= make_term(adot_w, q1_clcb_ff);
         q2_term_ff[5] <= make_term(ddot_w, -q1_slsb_ff);
         // z: the longitude axis has no z part
         q2_term_ff[6] <= make_term(q1_rdot_ff, q1_sb_ff);
         q2_term_ff[7] <= make_term(ddot_w, q1_cb_ff);
         q2_pos_ff[0]  <= sat_pos(q1_clcb_ff);
         q2_pos_ff[1]  <= sat_pos(q1_slcb_ff);
         q2_pos_ff[2]  <= sat_pos(q1_sb_ff);
      end
   end

   // stage 3: rounded signed terms
   logic               q3_valid_ff;
   logic signed [51:0] q3_val_ff [8];
   logic signed [31:0] q3_pos_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         q3_valid_ff <= 1'b0;
      end else if (en) begin
         q3_valid_ff <= q2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 8; k++) begin
            q3_val_ff[k] <= finish_term(q2_term_ff[k]);
         end
         for (int k = 0; k < 3; k++) begin
            q3_pos_ff[k] <= q2_pos_ff[k];
         end
      end
   end

   // stage 4: sum, saturate, result register
   logic signed [53:0] sum_x, sum_y, sum_z;
   logic               out_valid_ff;
   logic signed [31:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [47:0] vel_x_ff, vel_y_ff, vel_z_ff;

   assign sum_x = 54'(q3_val_ff[0]) + 54'(q3_val_ff[1]) + 54'(q3_val_ff[2]);
   assign sum_y = 54'(q3_val_ff[3]) + 54'(q3_val_ff[4]) + 54'(q3_val_ff[5]);
   assign sum_z = 54'(q3_val_ff[6]) + 54'(q3_val_ff[7]);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= q3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_x_ff <= q3_pos_ff[0];
         pos_y_ff <= q3_pos_ff[1];
         pos_z_ff <= q3_pos_ff[2];
         vel_x_ff <= sat_vel(sum_x);
         vel_y_ff <= sat_vel(sum_y);
         vel_z_ff <= sat_vel(sum_z);
      end
   end

   assign out_valid = out_valid_ff;
   assign pos_x     = pos_x_ff;
   assign pos_y     = pos_y_ff;
   assign pos_z     = pos_z_ff;
   assign vel_x     = vel_x_ff;
   assign vel_y     = vel_y_ff;
   assign vel_z     = vel_z_ff;

endmodule

@@ design/celestial_position_to_state_vector_unit.sv @@
// A request passes the front end, the row of rotation cells and the back end.
// Throughput: one request per cycle while the pipeline advances; every stage is a register, no unit is shared.
// The whole pipeline advances together; it holds only while a result waits
// in the output register and the consumer stalls.
// Reset (synchronous): clears all stage valid bits and loads velocity_scale
// and century_factor with their defaults.
// ----------------------------------------------------------------------------
// celestial_position_to_state_vector_unit
// Converts one catalog star (angles, proper motions, radial velocity,
// parallax) into a unit position vector and a velocity vector.
// ----------------------------------------------------------------------------
module celestial_position_to_state_vector_unit import cpsv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_longitude_deg,
   input  logic signed [29:0] req_latitude_deg,
   input  logic signed [31:0] req_pm_longitude,
   input  logic signed [31:0] req_pm_latitude,
   input  logic signed [31:0] req_radial_velocity,
   input  logic [31:0]        req_parallax_arcsec,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic signed [47:0] rsp_vel_x,
   output logic signed [47:0] rsp_vel_y,
   output logic signed [47:0] rsp_vel_z,
   // configuration
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_write_data
);

   // Configuration registers. Writes to unknown indexes are dropped.
   logic [31:0] velocity_scale_ff;
   logic [9:0]  century_factor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         velocity_scale_ff <= VELOCITY_SCALE_RESET;
         century_factor_ff <= CENTURY_FACTOR_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_VELOCITY_SCALE: velocity_scale_ff <= csr_write_data;
            CSR_CENTURY_FACTOR: century_factor_ff <= csr_write_data[9:0];
            default: ;
         endcase
      end
   end

   // Advance every stage unless the result register is full and stalled.
   // A taken result frees a slot in the same cycle, so requests stream at one
   // per cycle while the result register is empty or its result is taken.
   logic advance;

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // Front end: angle reduction, binary angle, rate products (4 stages).
   cell_type chain [CORDIC_STAGES + 1];

   cpsv_prep u_prep (
      .clock           (clock),
      .reset           (reset),
      .en              (advance),
      .in_valid        (req_valid),
      .longitude_deg   (req_longitude_deg),
      .latitude_deg    (req_latitude_deg),
      .pm_longitude    (req_pm_longitude),
      .pm_latitude     (req_pm_latitude),
      .radial_velocity (req_radial_velocity),
      .parallax_arcsec (req_parallax_arcsec),
      .velocity_scale  (velocity_scale_ff),
      .century_factor  (century_factor_ff),
      .cell_out        (chain[0])
   );

   // Row of rotation cells: cell i applies the 2^-i micro-rotation to both
   // angles and hands the star, with its rates, to cell i+1.
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      cpsv_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (advance),
         .stage_idx (5'(i)),
         .cell_in   (chain[i]),
         .cell_out  (chain[i + 1])
      );
   end

   // Back end: axis triad, rate times axis, sum and saturate (4 stages,
   // the last one is the result register).
   cpsv_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .cell_in   (chain[CORDIC_STAGES]),
      .out_valid (rsp_valid),
      .pos_x     (rsp_pos_x),
      .pos_y     (rsp_pos_y),
      .pos_z     (rsp_pos_z),
      .vel_x     (rsp_vel_x),
      .vel_y     (rsp_vel_y),
      .vel_z     (rsp_vel_z)
   );

endmodule
